### src/sti_pkg.sv
// shared types and constants for the sample table interpolator
// used by sti_mod_pipe, sti_interp and sample_table_interpolator_core
package sti_pkg;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'b1;

  // interpolation modes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_CUBIC  = 1'b1;

  localparam int SAMPLE_W   = 16;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // horner accumulator width, covers the largest doubled coefficient sum
  localparam int TW = 22;

  // control bits that travel with each word
  typedef struct packed {
    logic valid;
    logic rd;
  } sti_ctl_t;

endpackage

### src/sti_mod_pipe.sv
// pipelined index wrap: remainder of an unsigned index by the wave length
// one restoring step per stage, sideband carried along; uses sti_pkg
module sti_mod_pipe #(
  parameter int IW = 16,
  parameter int LW = 17,
  parameter int SW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  sti_pkg::sti_ctl_t   in_ctl,
  input  logic [IW-1:0]       in_num,
  input  logic [SW-1:0]       in_side,
  input  logic [LW-1:0]       len,
  output sti_pkg::sti_ctl_t   out_ctl,
  output logic [LW-1:0]       out_rem,
  output logic [SW-1:0]       out_side
);
  import sti_pkg::*;

  sti_ctl_t        ctl_r  [IW];
  logic [IW-1:0]   num_r  [IW-1];
  logic [LW-1:0]   rem_r  [IW];
  logic [SW-1:0]   side_r [IW];

  for (genvar k = 0; k < IW; k++) begin : g_stage
    sti_ctl_t      ctl_prev;
    logic [IW-1:0] num_prev;
    logic [LW-1:0] rem_prev;
    logic [SW-1:0] side_prev;
    logic [LW:0]   sh;
    logic [LW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign ctl_prev  = in_ctl;
      assign num_prev  = in_num;
      assign rem_prev  = '0;
      assign side_prev = in_side;
    end else begin : g_rest
      assign ctl_prev  = ctl_r[k-1];
      assign num_prev  = num_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign side_prev = side_r[k-1];
    end

    // bring in the next dividend bit, subtract the length once if it fits
    assign sh      = {rem_prev, num_prev[IW-1]};
    assign rem_nxt = (sh >= {1'b0, len}) ? LW'(sh - {1'b0, len}) : LW'(sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (adv) begin
        ctl_r[k] <= ctl_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        side_r[k] <= side_prev;
      end
    end

    if (k < IW - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (adv) begin
          num_r[k] <= num_prev << 1;
        end
      end
    end
  end

  assign out_ctl  = ctl_r[IW-1];
  assign out_rem  = rem_r[IW-1];
  assign out_side = side_r[IW-1];

endmodule

### src/sti_interp.sv
// interpolation datapath: coefficients, three horner multiplies, rounding,
// saturation and the output register; uses sti_pkg
module sti_interp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         mode,
  input  sti_pkg::sti_ctl_t            in_ctl,
  input  logic signed [sti_pkg::SAMPLE_W-1:0] y0,
  input  logic signed [sti_pkg::SAMPLE_W-1:0] y1,
  input  logic signed [sti_pkg::SAMPLE_W-1:0] y2,
  input  logic signed [sti_pkg::SAMPLE_W-1:0] y3,
  input  logic [FRAC_BITS-1:0]         frac,
  output logic                         res_valid,
  output logic signed [sti_pkg::SAMPLE_W-1:0] res_sample,
  output logic                         res_clip
);
  import sti_pkg::*;

  localparam int PW = TW + FRAC_BITS + 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

  // coefficient stage
  sti_ctl_t              c_ctl_r;
  logic signed [TW-1:0]  ca_r, cb_r, cc_r, cd_r, dl_r, c_y1_r;
  logic [FRAC_BITS-1:0]  c_frac_r;
  logic signed [TW-1:0]  e0, e1, e2, e3;
  logic signed [TW-1:0]  ca_nxt, cb_nxt, cc_nxt, cd_nxt, dl_nxt;

  assign e0 = TW'(y0);
  assign e1 = TW'(y1);
  assign e2 = TW'(y2);
  assign e3 = TW'(y3);

  assign ca_nxt = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
  assign cb_nxt = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign cc_nxt = e2 - e0;
  assign cd_nxt = e1 <<< 1;
  assign dl_nxt = e2 - e1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else if (adv) begin
      c_ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca_r     <= ca_nxt;
      cb_r     <= cb_nxt;
      cc_r     <= cc_nxt;
      cd_r     <= cd_nxt;
      dl_r     <= dl_nxt;
      c_y1_r   <= e1;
      c_frac_r <= frac;
    end
  end

  // first multiply: A*f and the linear slope times f
  sti_ctl_t              x1_ctl_r;
  logic signed [PW-1:0]  p1_r, pl1_r;
  logic signed [TW-1:0]  x1_cb_r, x1_cc_r, x1_cd_r, x1_y1_r;
  logic [FRAC_BITS-1:0]  x1_frac_r;
  logic signed [PW-1:0]  c_fs;

  assign c_fs = PW'($signed({1'b0, c_frac_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_ctl_r <= '0;
    end else if (adv) begin
      x1_ctl_r <= c_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r      <= PW'(ca_r) * c_fs;
      pl1_r     <= PW'(dl_r) * c_fs;
      x1_cb_r   <= cb_r;
      x1_cc_r   <= cc_r;
      x1_cd_r   <= cd_r;
      x1_y1_r   <= c_y1_r;
      x1_frac_r <= c_frac_r;
    end
  end

  // second multiply: (rnd(A*f) + B) * f
  sti_ctl_t              x2_ctl_r;
  logic signed [PW-1:0]  p2_r, pl2_r;
  logic signed [TW-1:0]  x2_cc_r, x2_cd_r, x2_y1_r;
  logic [FRAC_BITS-1:0]  x2_frac_r;
  logic signed [PW-1:0]  x1_fs, x1_rsh;
  logic signed [TW-1:0]  t2;

  assign x1_fs  = PW'($signed({1'b0, x1_frac_r}));
  assign x1_rsh = (p1_r + RND_HALF) >>> FRAC_BITS;
  assign t2     = TW'(x1_rsh) + x1_cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_ctl_r <= '0;
    end else if (adv) begin
      x2_ctl_r <= x1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r      <= PW'(t2) * x1_fs;
      pl2_r     <= pl1_r;
      x2_cc_r   <= x1_cc_r;
      x2_cd_r   <= x1_cd_r;
      x2_y1_r   <= x1_y1_r;
      x2_frac_r <= x1_frac_r;
    end
  end

  // third multiply: (rnd(t*f) + C) * f
  sti_ctl_t              x3_ctl_r;
  logic signed [PW-1:0]  p3_r, pl3_r;
  logic signed [TW-1:0]  x3_cd_r, x3_y1_r;
  logic signed [PW-1:0]  x2_fs, x2_rsh;
  logic signed [TW-1:0]  t3;

  assign x2_fs  = PW'($signed({1'b0, x2_frac_r}));
  assign x2_rsh = (p2_r + RND_HALF) >>> FRAC_BITS;
  assign t3     = TW'(x2_rsh) + x2_cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x3_ctl_r <= '0;
    end else if (adv) begin
      x3_ctl_r <= x2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r    <= PW'(t3) * x2_fs;
      pl3_r   <= pl2_r;
      x3_cd_r <= x2_cd_r;
      x3_y1_r <= x2_y1_r;
    end
  end

  // final rounding, mode select and saturation
  logic signed [PW-1:0]  x3_rsh, lin_sum, lin_rsh;
  logic signed [TW-1:0]  t4, cub, lin, res;
  logic signed [SAMPLE_W-1:0] sat_nxt;
  logic                  clip_nxt;

  assign x3_rsh  = (p3_r + RND_HALF) >>> FRAC_BITS;
  assign t4      = TW'(x3_rsh) + x3_cd_r;
  assign cub     = (t4 + TW'(1)) >>> 1;
  assign lin_sum = (PW'(x3_y1_r) <<< FRAC_BITS) + pl3_r + RND_HALF;
  assign lin_rsh = lin_sum >>> FRAC_BITS;
  assign lin     = TW'(lin_rsh);
  assign res     = (mode == MODE_CUBIC) ? cub : lin;

  always_comb begin
    priority if (res > TW'(SAMPLE_MAX)) begin
      sat_nxt  = SAMPLE_W'(SAMPLE_MAX);
      clip_nxt = 1'b1;
    end else if (res < TW'(SAMPLE_MIN)) begin
      sat_nxt  = SAMPLE_W'(SAMPLE_MIN);
      clip_nxt = 1'b1;
    end else begin
      sat_nxt  = SAMPLE_W'(res);
      clip_nxt = 1'b0;
    end
  end

  logic                        res_valid_r;
  logic signed [SAMPLE_W-1:0]  res_sample_r;
  logic                        res_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= x3_ctl_r.valid && x3_ctl_r.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_sample_r <= sat_nxt;
      res_clip_r   <= clip_nxt;
    end
  end

  assign res_valid  = res_valid_r;
  assign res_sample = res_sample_r;
  assign res_clip   = res_clip_r;

endmodule

### src/sample_table_interpolator_core.sv
// top level of the sample table interpolator: config registers, sample store
// and pipeline control; uses sti_pkg, sti_mod_pipe and sti_interp
//
// usage
//   input channel (in_valid / in_stall): one word per item. opcode write stores
//   in_sample_in at (position >> FRAC_BITS) mod length and gives no result.
//   opcode read gives one interpolated word on the result channel, linear or
//   catmull-rom cubic per interp_mode, saturated, with out_clipped on overflow.
//   config port: cfg_wen writes cfg_wdata to the register at cfg_addr
//   (0 wave_length, 1 interp_mode); write only while the pipeline is empty.
//   throughput: one word per cycle, writes and reads mixed, unless a result stalls.
//   path from accept to out_valid: one wrap stage per index bit, then address,
//   store read, coefficients, three multiply stages and the output register.
//   the wrap pipeline's length follows from the index width, 32 - FRAC_BITS.
//   stall: when a result waits under out_stall the whole pipeline holds and
//   in_stall rises; no word is dropped or repeated.
//   reset: control state and config registers return to defaults; the sample
//   store is not cleared and reads only what has been written.
module sample_table_interpolator_core #(
  parameter int WAVE_DEPTH = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [31:0]                         in_position,
  input  logic signed [sti_pkg::SAMPLE_W-1:0] in_sample_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sti_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_clipped,
  // configuration port
  input  logic                                cfg_wen,
  input  logic [sti_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [sti_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sti_pkg::*;

  localparam int IW = 32 - FRAC_BITS;              // index width
  localparam int AW = $clog2(WAVE_DEPTH);          // store address width
  localparam int LW = $clog2(WAVE_DEPTH + 1);      // length width, holds the depth
  localparam int SW = FRAC_BITS + SAMPLE_W;        // sideband through the wrap stages

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] wave_length_r;
  logic                  interp_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_length_r <= CFG_DATA_W'(65536);
      interp_mode_r <= MODE_CUBIC;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_WAVE_LENGTH: wave_length_r <= cfg_wdata;
        REG_INTERP_MODE: interp_mode_r <= cfg_wdata[0];
      endcase
    end
  end

  // effective length: clamped to [4, WAVE_DEPTH]
  logic [LW-1:0] len;

  always_comb begin
    priority if (32'(wave_length_r) < 32'd4) begin
      len = LW'(4);
    end else if (32'(wave_length_r) > 32'(WAVE_DEPTH)) begin
      len = LW'(WAVE_DEPTH);
    end else begin
      len = LW'(wave_length_r);
    end
  end

  // ---------------------------------------------------------------------
  // pipeline advance: everything moves unless a result is held by the sink
  // ---------------------------------------------------------------------
  logic adv;
  logic res_valid;

  assign adv      = !res_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // index wrap pipeline, one quotient bit per stage
  // ---------------------------------------------------------------------
  sti_ctl_t       in_ctl;
  sti_ctl_t       w_ctl;
  logic [LW-1:0]  w_idx;
  logic [SW-1:0]  w_side;

  assign in_ctl.valid = in_valid;
  assign in_ctl.rd    = (in_opcode == OP_READ);

  sti_mod_pipe #(
    .IW (IW),
    .LW (LW),
    .SW (SW)
  ) u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ctl   (in_ctl),
    .in_num   (in_position[31:FRAC_BITS]),
    .in_side  ({in_position[FRAC_BITS-1:0], in_sample_in}),
    .len      (len),
    .out_ctl  (w_ctl),
    .out_rem  (w_idx),
    .out_side (w_side)
  );

  // ---------------------------------------------------------------------
  // tap address stage: idx-1, idx, idx+1, idx+2, each wrapped into the length
  // ---------------------------------------------------------------------
  logic [LW:0] ix, lx, inc1, inc2;
  logic [LW:0] t0_nxt, t2_nxt, t3_nxt;

  assign ix   = {1'b0, w_idx};
  assign lx   = {1'b0, len};
  assign inc1 = ix + (LW+1)'(1);
  assign inc2 = ix + (LW+1)'(2);

  assign t0_nxt = (ix == '0)    ? lx - (LW+1)'(1) : ix - (LW+1)'(1);
  assign t2_nxt = (inc1 == lx)  ? '0              : inc1;
  assign t3_nxt = (inc2 >= lx)  ? inc2 - lx       : inc2;

  sti_ctl_t                    a_ctl_r;
  logic [AW-1:0]               a0_r, a1_r, a2_r, a3_r;
  logic [FRAC_BITS-1:0]        a_frac_r;
  logic signed [SAMPLE_W-1:0]  a_smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else if (adv) begin
      a_ctl_r <= w_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r     <= t0_nxt[AW-1:0];
      a1_r     <= ix[AW-1:0];
      a2_r     <= t2_nxt[AW-1:0];
      a3_r     <= t3_nxt[AW-1:0];
      a_frac_r <= w_side[SW-1:SAMPLE_W];
      a_smp_r  <= $signed(w_side[SAMPLE_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // sample store: two copies, each with two read ports, written together
  // a write word lands here in program order, so a later read sees it
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] store_a_r [WAVE_DEPTH];
  logic signed [SAMPLE_W-1:0] store_b_r [WAVE_DEPTH];
  logic                       st_we;

  assign st_we = rst_n && adv && a_ctl_r.valid && !a_ctl_r.rd;

  sti_ctl_t                    m_ctl_r;
  logic signed [SAMPLE_W-1:0]  y0_r, y1_r, y2_r, y3_r;
  logic [FRAC_BITS-1:0]        m_frac_r;

  // copy a serves the taps at idx-1 and idx
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_a_r[a1_r] <= a_smp_r;
    end
    if (adv) begin
      y0_r <= store_a_r[a0_r];
      y1_r <= store_a_r[a1_r];
    end
  end

  // copy b serves the taps at idx+1 and idx+2
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_b_r[a1_r] <= a_smp_r;
    end
    if (adv) begin
      y2_r <= store_b_r[a2_r];
      y3_r <= store_b_r[a3_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctl_r <= '0;
    end else if (adv) begin
      m_ctl_r <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_frac_r <= a_frac_r;
    end
  end

  // ---------------------------------------------------------------------
  // interpolation datapath and output register
  // ---------------------------------------------------------------------
  sti_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .mode       (interp_mode_r),
    .in_ctl     (m_ctl_r),
    .y0         (y0_r),
    .y1         (y1_r),
    .y2         (y2_r),
    .y3         (y3_r),
    .frac       (m_frac_r),
    .res_valid  (res_valid),
    .res_sample (out_sample_out),
    .res_clip   (out_clipped)
  );

  assign out_valid = res_valid;

endmodule

### tb/sv/sample_table_interpolator_core_tb.sv
// testbench for sample_table_interpolator_core: directed wrap and clip cases,
// then random write / read traffic over several lengths and both modes
// depends on sti_pkg and the sample_table_interpolator_core rtl
module sample_table_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sti_pkg::*;

  localparam int FRAC         = 16;
  localparam int DEPTH        = 65536;
  localparam int PIPE_LATENCY = 39 - FRAC;
  localparam int CYCLE_LIMIT  = 200000;

  // one result word as seen on the output channel
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } interp_word_t;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_opcode    = OP_WRITE;
  logic [31:0]                in_position  = '0;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_stall    = 1'b0;
  logic                       cfg_wen      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_addr     = REG_WAVE_LENGTH;
  logic [CFG_DATA_W-1:0]      cfg_wdata    = '0;
  wire                        in_stall;
  wire                        out_valid;
  wire signed [SAMPLE_W-1:0]  out_sample_out;
  wire                        out_clipped;

  // shadow copy of the config registers and the sample store
  logic [CFG_DATA_W-1:0]      wave_len_q    = 17'd65536;
  logic                       interp_mode_q = MODE_CUBIC;
  logic signed [SAMPLE_W-1:0] wave_mem [0:DEPTH-1];
  bit                         wave_written [0:DEPTH-1];
  int unsigned                filled_addrs [$];

  // interpolated words still owed by the block, oldest first
  interp_word_t expected_q [$];
  interp_word_t head_word;

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int unsigned hold_cycles    = 0;

  sample_table_interpolator_core #(
    .WAVE_DEPTH(DEPTH),
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // length register clamped to what the store can hold
  function automatic int unsigned eff_wave_len();
    if (wave_len_q < 4) return 4;
    if (wave_len_q > DEPTH) return DEPTH;
    return 32'(wave_len_q);
  endfunction

  // round to nearest, ties up, on a Q.FRAC product
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic interp_word_t interpolate(logic [31:0] pos);
    int unsigned  len;
    int unsigned  idx;
    longint       f, y0, y1, y2, y3, t;
    interp_word_t w;
    len = eff_wave_len();
    idx = (pos >> FRAC) % len;
    f   = longint'(pos[FRAC-1:0]);
    y0  = longint'(wave_mem[(idx + len - 1) % len]);
    y1  = longint'(wave_mem[idx]);
    y2  = longint'(wave_mem[(idx + 1) % len]);
    y3  = longint'(wave_mem[(idx + 2) % len]);
    if (interp_mode_q == MODE_LINEAR) begin
      t = round_frac((y1 <<< FRAC) + (y2 - y1) * f);
    end else begin
      // horner over doubled catmull-rom coefficients, rounding each product
      t = -y0 + 3 * y1 - 3 * y2 + y3;
      t = round_frac(t * f) + (2 * y0 - 5 * y1 + 4 * y2 - y3);
      t = round_frac(t * f) + (-y0 + y2);
      t = round_frac(t * f) + 2 * y1;
      t = (t + 1) >>> 1;
    end
    w.clipped = 1'b0;
    if (t > SAMPLE_MAX) begin
      t = longint'(SAMPLE_MAX);
      w.clipped = 1'b1;
    end else if (t < SAMPLE_MIN) begin
      t = longint'(SAMPLE_MIN);
      w.clipped = 1'b1;
    end
    w.sample = t[SAMPLE_W-1:0];
    return w;
  endfunction

  // a write lands at index mod length
  function automatic void store_sample(logic [31:0] pos, logic signed [SAMPLE_W-1:0] smp);
    int unsigned idx;
    idx = (pos >> FRAC) % eff_wave_len();
    wave_mem[idx] = smp;
    if (!wave_written[idx]) begin
      wave_written[idx] = 1'b1;
      filled_addrs = {filled_addrs, idx};
    end
  endfunction

  // all four neighbours written, so the read never touches an unwritten entry
  function automatic bit taps_ready(int unsigned idx);
    int unsigned len;
    len = eff_wave_len();
    return wave_written[(idx + len - 1) % len] && wave_written[idx] &&
           wave_written[(idx + 1) % len] && wave_written[(idx + 2) % len];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [FRAC-1:0] pick_frac();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(FRAC - 1){1'b0}}};
      default: return FRAC'($urandom());
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_W'(SAMPLE_MAX);
      1:       return SAMPLE_W'(SAMPLE_MIN);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // position for a store index, with a random number of wraps above it
  function automatic logic [31:0] make_pos(int unsigned addr);
    int unsigned len;
    int unsigned k;
    len = eff_wave_len();
    k   = $urandom_range(0, (((1 << (32 - FRAC)) - 1) - addr) / len);
    return ((addr + k * len) << FRAC) | pick_frac();
  endfunction

  function automatic bit pick_read_addr(output int unsigned addr);
    int unsigned len;
    len  = eff_wave_len();
    addr = 0;
    repeat (12) begin
      if (filled_addrs.size() != 0) begin
        addr = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
        if (addr < len && taps_ready(addr)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void set_profile(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endfunction

  // offer one word, hold it until taken, then update the shadow state
  task automatic send_word(input logic op, input logic [31:0] pos,
                           input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_position  <= pos;
    in_sample_in <= smp;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (op == OP_READ) expected_q = {expected_q, interpolate(pos)};
    else store_sample(pos, smp);
  endtask

  // empty the pipeline; writes leave no result, so allow their latency too
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // both registers back to back, block idle; mode carries junk upper bits
  task automatic set_config(input logic [CFG_DATA_W-1:0] len_val, input logic mode_val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= REG_WAVE_LENGTH;
    cfg_wdata <= len_val;
    @(posedge clk);
    cfg_addr  <= REG_INTERP_MODE;
    cfg_wdata <= {(CFG_DATA_W - 1)'($urandom()), mode_val};
    @(posedge clk);
    cfg_wen       <= 1'b0;
    wave_len_q    = len_val;
    interp_mode_q = mode_val;
  endtask

  task automatic read_at(input int unsigned idx, input logic [FRAC-1:0] frac);
    send_word(OP_READ, (idx << FRAC) | frac, pick_sample());
  endtask

  // write every entry below count, through wrapped positions
  task automatic fill_wave(input int unsigned count);
    for (int unsigned a = 0; a < count; a++) send_word(OP_WRITE, make_pos(a), pick_sample());
  endtask

  // random traffic; idle profile moves through its three settings
  task automatic run_mixed(input int count, input int write_pct);
    int unsigned addr;
    int unsigned len;
    int unsigned base;
    logic [31:0] pos;
    for (int i = 0; i < count; i++) begin
      case (i * 3 / count)
        0:       set_profile(22, 45);
        1:       set_profile(45, 22);
        default: set_profile(0, 0);
      endcase
      len = eff_wave_len();
      if ($urandom_range(0, 99) >= write_pct && pick_read_addr(addr)) begin
        send_word(OP_READ, make_pos(addr), pick_sample());
      end else begin
        // half the writes grow the filled region, half land anywhere
        if ($urandom_range(0, 1) && filled_addrs.size() != 0) begin
          base = (filled_addrs[$urandom_range(0, filled_addrs.size() - 1)] + len - 2 +
                  $urandom_range(0, 4)) % len;
          pos  = make_pos(base);
        end else begin
          pos = $urandom();
        end
        send_word(OP_WRITE, pos, pick_sample());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults: full length, cubic; extreme samples around the wrap point
  task automatic test_wrap_and_clip();
    int unsigned                wrap_idx [8] = '{65534, 65535, 0, 1, 2, 3, 4, 5};
    logic signed [SAMPLE_W-1:0] wrap_val [8] = '{16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff,
                                                 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff};
    set_profile(22, 45);
    for (int i = 0; i < 8; i++)
      send_word(OP_WRITE, (wrap_idx[i] << FRAC) | pick_frac(), wrap_val[i]);
    read_at(65535, 16'h8000);  // overshoot below full scale, clips low
    read_at(1, 16'h8000);      // overshoot above full scale, clips high
    read_at(0, 16'h0000);      // zero fraction returns the tap itself
    read_at(2, 16'hffff);      // largest fraction
    read_at(3, 16'h8000);
    drain_pipe();
    // same data in linear mode never clips
    set_config(17'd65536, MODE_LINEAR);
    read_at(65535, 16'hffff);
    read_at(1, 16'h8000);
    read_at(0, 16'h0001);
  endtask

  // shortest wave, every index wraps through the upper position bits
  task automatic test_min_length();
    drain_pipe();
    set_config(17'd4, MODE_CUBIC);
    fill_wave(4);
    run_mixed(80, 30);
  endtask

  // lengths below the legal range act as four
  task automatic test_length_below_range();
    drain_pipe();
    set_config(17'd0, MODE_LINEAR);
    run_mixed(60, 30);
    drain_pipe();
    set_config(17'd3, MODE_CUBIC);
    run_mixed(30, 30);
  endtask

  // lengths above the store depth act as the full store
  task automatic test_length_above_range();
    drain_pipe();
    set_config('1, MODE_CUBIC);
    run_mixed(70, 40);
  endtask

  // odd length, linear blend across the wrap
  task automatic test_odd_length();
    drain_pipe();
    set_config(17'd37, MODE_LINEAR);
    fill_wave(37);
    run_mixed(70, 30);
  endtask

  // long receiver hold while reads keep coming, so in_stall must rise
  task automatic test_backpressure();
    int unsigned addr;
    drain_pipe();
    set_config(17'd64, MODE_CUBIC);
    fill_wave(64);
    set_profile(0, 0);
    hold_cycles = 300;
    repeat (80) begin
      addr = $urandom_range(0, 63);
      send_word(OP_READ, make_pos(addr), pick_sample());
    end
    run_mixed(40, 25);
  endtask

  // back to the full store in linear mode
  task automatic test_full_length_linear();
    drain_pipe();
    set_config(17'd65536, MODE_LINEAR);
    run_mixed(60, 40);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------

  // random stall, or a counted hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // each taken word against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: word with none expected: expected no word, actual sample_out %0d clipped %0b",
                 $time, out_sample_out, out_clipped);
      end else begin
        head_word = expected_q.pop_front();
        if (out_sample_out !== head_word.sample) begin
          mismatch_count++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, head_word.sample, out_sample_out);
        end
        if (out_clipped !== head_word.clipped) begin
          mismatch_count++;
          $display("%0t: clipped mismatch: expected %0b, actual %0b",
                   $time, head_word.clipped, out_clipped);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_wrap_and_clip();
    test_min_length();
    test_length_below_range();
    test_length_above_range();
    test_odd_length();
    test_backpressure();
    test_full_length_linear();
    drain_pipe();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/sti_pkg.sv
src/sti_mod_pipe.sv
src/sti_interp.sv
src/sample_table_interpolator_core.sv
tb/sv/sample_table_interpolator_core_tb.sv
